FILE: hw/rtl/msb_first_varint_codec_macros.svh
// ----------------------------------------------------------------------------
// msb_first_varint_codec_macros.svh
// assertion macros shared by the codec checker
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_VARINT_CODEC_MACROS_SVH
`define MSB_FIRST_VARINT_CODEC_MACROS_SVH

// same-cycle implication, disabled during reset
`define MSBVC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("codec check failed");

// next-cycle implication, disabled during reset
`define MSBVC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("codec check failed");

`endif

FILE: hw/rtl/msbvc_pkg.sv
// ----------------------------------------------------------------------------
// msbvc_pkg
// types, widths and helpers for the msb-first base-128 varint codec
// ----------------------------------------------------------------------------
package msbvc_pkg;

   localparam int VALUE_W    = 64;
   localparam int BYTE_W     = 8;
   localparam int COUNT_W    = 8;
   localparam int GROUP_W    = 7;
   localparam int NUM_GROUPS = 10;
   localparam int GIDX_W     = 4;
   localparam int REQ_DATA_W = VALUE_W + BYTE_W;            // 72, whole bytes
   localparam int RSP_DATA_W = BYTE_W + VALUE_W + COUNT_W;  // 80, whole bytes

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef logic [GIDX_W-1:0]  gidx_type;
   typedef logic [GROUP_W-1:0] group_type;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   typedef enum logic {
      KIND_BYTE  = 1'b0,
      KIND_VALUE = 1'b1
   } kind_type;

   // group g of x: top group is bit 63 alone, others are 7-bit slices
   function automatic group_type group_of(logic [VALUE_W-1:0] x, gidx_type g);
      group_type res;
      res = '0;
      for (int i = 0; i < NUM_GROUPS - 1; i++) begin
         if (g == gidx_type'(i)) begin
            res = x[i*GROUP_W +: GROUP_W];
         end
      end
      if (g == gidx_type'(NUM_GROUPS - 1)) begin
         res = group_type'(x[VALUE_W-1]);
      end
      return res;
   endfunction

   // index of the highest nonzero group, group 0 when all are zero
   function automatic gidx_type top_group(logic [VALUE_W-1:0] x);
      gidx_type top;
      top = '0;
      for (int i = 1; i < NUM_GROUPS; i++) begin
         if (group_of(x, gidx_type'(i)) != '0) begin
            top = gidx_type'(i);
         end
      end
      return top;
   endfunction

endpackage

FILE: hw/rtl/msb_first_varint_codec.sv
// ----------------------------------------------------------------------------
// msb_first_varint_codec
// encodes 64-bit values into msb-first base-128 bytes, decodes bytes back
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                      | tuser | tlast
//  req     | in  | value[63:0], in_byte[71:64]             | op    | -
//  rsp     | out | out_byte[7:0], out_value[71:8],         | kind  | last
//          |     | byte_count[79:72]                       |       |
//
//  an encode item stays in the work register until its 1 to 10 bytes are
//  formed, one group per cycle while rsp is unstalled; decode holds one byte.
//  a result is registered and appears on rsp in the cycle after it is formed.
//  a new item is taken in the cycle the current one finishes.
//  reset (synchronous, active high) clears both valids and the decode state.
//  a stalled rsp holds the work register; decode continuation bytes still go.
// ----------------------------------------------------------------------------
module msb_first_varint_codec
   import msbvc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // value, in_byte
   input  logic                  req_tuser,   // op
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_byte, out_value, byte_count
   output logic                  rsp_tuser,   // result_kind
   output logic                  rsp_tlast    // last
);

   // work register
   logic               a_valid_ff, a_valid_in;
   op_type             a_op_ff, a_op_in;
   logic [VALUE_W-1:0] a_value_ff, a_value_in;
   logic [BYTE_W-1:0]  a_byte_ff, a_byte_in;
   gidx_type           a_grp_ff, a_grp_in;

   // decode state
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0] seen_ff, seen_in;

   // result register
   logic                  b_valid_ff, b_valid_in;
   kind_type              b_kind_ff, b_kind_in;
   logic                  b_last_ff, b_last_in;
   logic [RSP_DATA_W-1:0] b_data_ff, b_data_in;

   logic               out_ok, fire, has_result, a_done, accept;
   logic               is_cont;
   group_type          grp_bits;
   logic [COUNT_W-1:0] count_next;

   assign out_ok     = !b_valid_ff || rsp_tready;
   assign is_cont    = (a_op_ff == OP_DECODE) && a_byte_ff[BYTE_W-1];
   assign has_result = a_valid_ff && !is_cont;
   assign fire       = a_valid_ff && (is_cont || out_ok);
   assign a_done     = fire && ((a_op_ff == OP_DECODE) || (a_grp_ff == '0));
   assign req_tready = !a_valid_ff || a_done;
   assign accept     = req_tvalid && req_tready;

   assign grp_bits   = group_of(a_value_ff, a_grp_ff);
   assign count_next = (seen_ff == COUNT_MAX) ? COUNT_MAX : seen_ff + COUNT_W'(1);

   always_comb begin
      a_valid_in = a_valid_ff;
      a_op_in    = a_op_ff;
      a_value_in = a_value_ff;
      a_byte_in  = a_byte_ff;
      a_grp_in   = a_grp_ff;
      if (accept) begin
         a_valid_in = 1'b1;
         a_op_in    = op_type'(req_tuser);
         a_value_in = req_tdata[VALUE_W-1:0];
         a_byte_in  = req_tdata[REQ_DATA_W-1:VALUE_W];
         a_grp_in   = top_group(req_tdata[VALUE_W-1:0]);
      end else if (a_done) begin
         a_valid_in = 1'b0;
      end else if (fire) begin
         // next lower group of the same encode item
         a_grp_in = a_grp_ff - GIDX_W'(1);
      end
   end

   always_comb begin
      acc_in  = acc_ff;
      seen_in = seen_ff;
      if (fire && (a_op_ff == OP_DECODE)) begin
         if (is_cont) begin
            acc_in  = (acc_ff | VALUE_W'(a_byte_ff[GROUP_W-1:0])) << GROUP_W;
            seen_in = count_next;
         end else begin
            acc_in  = '0;
            seen_in = '0;
         end
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff && !rsp_tready;
      b_kind_in  = b_kind_ff;
      b_last_in  = b_last_ff;
      b_data_in  = b_data_ff;
      if (fire && has_result) begin
         b_valid_in = 1'b1;
         if (a_op_ff == OP_ENCODE) begin
            b_kind_in = KIND_BYTE;
            b_last_in = (a_grp_ff == '0);
            b_data_in = RSP_DATA_W'({(a_grp_ff != '0), grp_bits});
         end else begin
            b_kind_in = KIND_VALUE;
            b_last_in = 1'b1;
            b_data_in = {count_next, acc_ff | VALUE_W'(a_byte_ff), {BYTE_W{1'b0}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         acc_ff     <= '0;
         seen_ff    <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         acc_ff     <= acc_in;
         seen_ff    <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff    <= a_op_in;
      a_value_ff <= a_value_in;
      a_byte_ff  <= a_byte_in;
      a_grp_ff   <= a_grp_in;
      b_kind_ff  <= b_kind_in;
      b_last_ff  <= b_last_in;
      b_data_ff  <= b_data_in;
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = b_data_ff;
   assign rsp_tuser  = b_kind_ff;
   assign rsp_tlast  = b_last_ff;

endmodule

FILE: hw/rtl/msbvc_checker.sv
// ----------------------------------------------------------------------------
// msbvc_checker
// port-level checks for the msb-first varint codec
// ----------------------------------------------------------------------------
`include "msb_first_varint_codec_macros.svh"

module msbvc_checker
   import msbvc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,   // out_byte, out_value, byte_count
   input logic                  rsp_tuser,   // result_kind
   input logic                  rsp_tlast    // last
);

   logic                  rsp_xfer, rsp_stall, rsp_is_byte, rsp_is_value;
   logic                  enc_more_xfer, enc_fields_ok, dec_fields_ok;
   logic [RSP_DATA_W+1:0] rsp_word;

   assign rsp_xfer      = rsp_tvalid && rsp_tready;
   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign rsp_is_byte   = (rsp_tuser == KIND_BYTE);
   assign rsp_is_value  = (rsp_tuser == KIND_VALUE);
   assign enc_more_xfer = rsp_xfer && rsp_is_byte && !rsp_tlast;
   assign rsp_word      = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign enc_fields_ok = (rsp_tdata[BYTE_W-1] != rsp_tlast)
                          && (rsp_tdata[RSP_DATA_W-1:BYTE_W] == '0);
   assign dec_fields_ok = rsp_tlast && (rsp_tdata[BYTE_W-1:0] == '0)
                          && (rsp_tdata[RSP_DATA_W-1:RSP_DATA_W-COUNT_W] != '0);

   // stalled result holds
   `MSBVC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // bytes of one encoded value leave without gaps
   `MSBVC_ASSERT_NXT(a_enc_burst, clock, reset, enc_more_xfer, rsp_tvalid && rsp_is_byte)

   // continuation flag is the inverse of the last marker, value and count stay zero
   `MSBVC_ASSERT_IMP(a_enc_fields, clock, reset, rsp_tvalid && rsp_is_byte, enc_fields_ok)

   // decoded value is a single last result with a nonzero count
   `MSBVC_ASSERT_IMP(a_dec_fields, clock, reset, rsp_tvalid && rsp_is_value, dec_fields_ok)

endmodule

bind msb_first_varint_codec msbvc_checker u_msbvc_checker (.*);
